// File: hw/rtl/bdd_pkg.sv
`default_nettype none
package bdd_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_WINDOW_SIZE = 5;

  localparam int WREGS    = 5;
  localparam int LINES    = 4;
  localparam int SAMPLE_W = 20;
  localparam int SIZE_W   = 11;
  localparam int SIGMA_W  = 19;
  localparam int CFG_IDX_W = 2;

  localparam int SUM_W = SAMPLE_W + 5;
  localparam int CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SIGMA  = 2'd2;

  localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT = 11'd480;
  localparam logic [SIGMA_W-1:0] RST_RANGE_SIGMA  = 19'd160;

endpackage
`default_nettype wire

// File: hw/rtl/bilateral_depth_downsample_top.sv
// Flow: an accepted pixel stalls the input while S_RD issues its line reads and then
// writes the sample back; a pixel that completes a window then takes a centre read, 25
// window steps, 25 divide steps and an output load, after which its result shows. A new
// pixel is taken only once the last is done, and a result that waits on a stalled
// earlier result keeps the input stalled until it can be loaded.
// Reset: async active low; control, window and config reset; datapath, line store not.
`default_nettype none
module bilateral_depth_downsample_top
  import bdd_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [SIGMA_W-1:0]    cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [SAMPLE_W-1:0]   depth_sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]        down_depth_o,
  output logic                       frame_last_o
);

  localparam int RadRaw = WINDOW_SIZE / 2;
  localparam int Rad = (RadRaw < 1) ? 1 : ((RadRaw > 2) ? 2 : RadRaw);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(LINES * MAX_WIDTH);
  localparam int DwW = $clog2(MAX_WIDTH + 1);
  localparam int DhW = $clog2(MAX_HEIGHT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CTR  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  function automatic int centre_pos(int pos, int size);
    int c;
    c = (((size - 2) & 1) == 0) ? size - 2 : size - 3;
    return (pos < size - 1) ? pos - Rad : c;
  endfunction

  function automatic logic centre_ok(int pos, int size);
    int c;
    c = (((size - 2) & 1) == 0) ? size - 2 : size - 3;
    if (pos < size - 1) return !(pos < Rad || ((pos - Rad) & 1) != 0);
    return (c >= 0) && (c + Rad >= size - 1);
  endfunction

  logic [SIZE_W-1:0]  fw_q, fh_q;
  logic [SIGMA_W-1:0] sigma_q;
  logic [CW-1:0] col_cnt_q;
  logic [RW-1:0] row_cnt_q;
  logic [2:0] state_q;
  logic [2:0] k_q;
  logic [CW-1:0] col_q;
  logic [1:0] row_lo_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] win_q [WREGS][WREGS];
  logic emit_q, last_q;
  logic [WREGS-1:0] rmask_q, cmask_q;
  logic [2:0] dr_q, dc_q;
  logic [2:0] ki_q, kj_q;
  logic [SAMPLE_W-1:0] cen_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W:0] rem_q;
  logic [4:0] step_q;
  logic ovalid_q, olast_q;
  logic [SAMPLE_W-1:0] odepth_q;

  logic [SAMPLE_W-1:0] mem [LINES * MAX_WIDTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic mem_we;

  logic accept;
  logic [DwW-1:0] w_cl;
  logic [DhW-1:0] h_cl;
  int w_i, h_i, r_i, c_i, ey, ex;
  logic emit_d;
  logic [WREGS-1:0] rmask_d, cmask_d;
  logic [2:0] rsel_k, rsel_j;
  logic [SAMPLE_W-1:0] win_rd;
  logic [SIGMA_W+1:0] thresh;
  logic [SAMPLE_W-1:0] diff;
  logic [CNT_W+1:0] trial;
  logic out_load;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    if (fw_q < SIZE_W'(2)) w_cl = DwW'(2);
    else if (32'(fw_q) > MAX_WIDTH) w_cl = DwW'(MAX_WIDTH);
    else w_cl = DwW'(fw_q);
    if (fh_q < SIZE_W'(2)) h_cl = DhW'(2);
    else if (32'(fh_q) > MAX_HEIGHT) h_cl = DhW'(MAX_HEIGHT);
    else h_cl = DhW'(fh_q);
    w_i = int'(w_cl);
    h_i = int'(h_cl);
    r_i = int'(row_cnt_q);
    c_i = int'(col_cnt_q);
    ey = centre_pos(r_i, h_i);
    ex = centre_pos(c_i, w_i);
    emit_d = centre_ok(r_i, h_i) && centre_ok(c_i, w_i) &&
             (r_i - ey <= WREGS - 1) && (c_i - ex <= WREGS - 1);
    for (int k = 0; k < WREGS; k++) begin
      rmask_d[k] = (r_i - (WREGS - 1) + k >= 0) && (r_i - (WREGS - 1) + k >= ey - Rad) &&
                   (r_i - (WREGS - 1) + k <= ey + Rad) && (r_i - (WREGS - 1) + k <= h_i - 1);
      cmask_d[k] = (c_i - (WREGS - 1) + k >= 0) && (c_i - (WREGS - 1) + k >= ex - Rad) &&
                   (c_i - (WREGS - 1) + k <= ex + Rad) && (c_i - (WREGS - 1) + k <= w_i - 1);
    end
  end

  // Line reads go out in S_RD; the sample is written back after the last read.
  always_comb begin
    raddr = AW'(int'(2'(row_lo_q + k_q[1:0])) * MAX_WIDTH + int'(col_q));
    waddr = AW'(int'(row_lo_q) * MAX_WIDTH + int'(col_q));
    mem_we = (state_q == S_RD) && (k_q == 3'd4);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= sample_q;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    if (state_q == S_CTR) begin
      rsel_k = 3'(WREGS - 1) - dr_q;
      rsel_j = 3'(WREGS - 1) - dc_q;
    end else begin
      rsel_k = ki_q;
      rsel_j = kj_q;
    end
    win_rd = win_q[rsel_k][rsel_j];
    thresh = (SIGMA_W+2)'(sigma_q) + (SIGMA_W+2)'({sigma_q, 1'b0});
    diff = (win_rd > cen_q) ? win_rd - cen_q : cen_q - win_rd;
    trial = {rem_q, sum_q[SUM_W-1]};
    out_load = (state_q == S_OUT) && (!ovalid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= RST_FRAME_WIDTH;
      fh_q <= RST_FRAME_HEIGHT;
      sigma_q <= RST_RANGE_SIGMA;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  fw_q <= cfg_data_i[SIZE_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= cfg_data_i[SIZE_W-1:0];
        REG_RANGE_SIGMA:  sigma_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      k_q <= '0;
      ovalid_q <= 1'b0;
      for (int k = 0; k < WREGS; k++) begin
        for (int j = 0; j < WREGS; j++) win_q[k][j] <= '0;
      end
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            for (int k = 0; k < WREGS; k++) begin
              for (int j = 0; j < WREGS - 1; j++) win_q[k][j] <= win_q[k][j+1];
            end
            win_q[WREGS-1][WREGS-1] <= depth_sample_i;
            if (c_i >= w_i - 1) begin
              col_cnt_q <= '0;
              if (r_i >= h_i - 1) row_cnt_q <= '0;
              else row_cnt_q <= row_cnt_q + 1'b1;
            end else begin
              col_cnt_q <= col_cnt_q + 1'b1;
            end
            k_q <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (k_q != 3'd0) win_q[{1'b0, 2'(k_q[1:0] - 2'd1)}][WREGS-1] <= rdata_q;
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) state_q <= emit_q ? S_CTR : S_IDLE;
        end
        S_CTR: state_q <= S_ACC;
        S_ACC: begin
          if (ki_q == 3'(WREGS - 1) && kj_q == 3'(WREGS - 1)) state_q <= S_DIV;
        end
        S_DIV: begin
          if (step_q == 5'(SUM_W - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath: window walk accumulates sum and count, then a restoring divide
  // shifts the quotient into the sum register one bit per cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          sample_q <= depth_sample_i;
          col_q <= col_cnt_q;
          row_lo_q <= row_cnt_q[1:0];
          emit_q <= emit_d;
          last_q <= (r_i >= h_i - 1) && (c_i >= w_i - 1);
          rmask_q <= rmask_d;
          cmask_q <= cmask_d;
          dr_q <= 3'(r_i - ey);
          dc_q <= 3'(c_i - ex);
        end
      end
      S_CTR: begin
        cen_q <= win_rd;
        ki_q <= '0;
        kj_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
      end
      S_ACC: begin
        if (rmask_q[ki_q] && cmask_q[kj_q] && ((SIGMA_W+2)'(diff) < thresh)) begin
          sum_q <= sum_q + SUM_W'(win_rd);
          cnt_q <= cnt_q + 1'b1;
        end
        if (kj_q == 3'(WREGS - 1)) begin
          kj_q <= '0;
          ki_q <= ki_q + 3'd1;
        end else begin
          kj_q <= kj_q + 3'd1;
        end
        rem_q <= '0;
        step_q <= '0;
      end
      S_DIV: begin
        step_q <= step_q + 5'd1;
        if (trial >= (CNT_W+2)'(cnt_q)) begin
          rem_q <= (CNT_W+1)'(trial - (CNT_W+2)'(cnt_q));
          sum_q <= {sum_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_q <= trial[CNT_W:0];
          sum_q <= {sum_q[SUM_W-2:0], 1'b0};
        end
      end
      S_OUT: begin
        if (out_load) begin
          odepth_q <= (cnt_q == '0) ? '0 : sum_q[SAMPLE_W-1:0];
          olast_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign down_depth_o = odepth_q;
  assign frame_last_o = olast_q;

endmodule
`default_nettype wire

// File: hw/rtl/bdd_checker.sv
`default_nettype none
module bdd_checker
  import bdd_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [SAMPLE_W-1:0]  down_depth_o,
  input wire logic                 frame_last_o
);

  // An accepted input transaction always stalls the input in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

  // A result only appears while an input transaction is being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(down_depth_o) && $stable(frame_last_o))
    else $error("output payload changed while stalled");

endmodule

bind bilateral_depth_downsample_top bdd_checker u_bdd_checker (.*);
`default_nettype wire
